### hw/rtl/abkf_pkg.sv
package abkf_pkg;

    localparam int DataWidth = 32;
    localparam int DtWidth   = 24;
    localparam int FracBits  = 24;
    localparam int CfgIdxWidth = 2;

    localparam logic [DataWidth-1:0] QaReset   = 32'd16777;
    localparam logic [DataWidth-1:0] QbReset   = 32'd50332;
    localparam logic [DataWidth-1:0] RReset    = 32'd503316;
    localparam logic [DataWidth-1:0] BiasReset = 32'd196608;

    localparam logic [CfgIdxWidth-1:0] CfgQa = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgQb = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgR  = 2'd2;

    // wide working value: products of two 35-bit operands fit below 2^70
    localparam int WideWidth = 72;
    localparam int DivWidth  = 58;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_ANGLE,
        ST_T,
        ST_INNER,
        ST_P00,
        ST_P11,
        ST_S,
        ST_DIV0,
        ST_DIV0_WAIT,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_CA,
        ST_CB,
        ST_C00,
        ST_C01,
        ST_C10,
        ST_C11,
        ST_OUT
    } abkf_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RATE,
        OP_ANGLE,
        OP_T,
        OP_INNER,
        OP_P00,
        OP_P11,
        OP_S,
        OP_DIV0,
        OP_DIV1,
        OP_CA,
        OP_CB,
        OP_C00,
        OP_C01,
        OP_C10,
        OP_C11
    } abkf_op_t;

    typedef struct packed {
        logic     load;
        abkf_op_t op;
        logic     div_start;
        logic     out_load;
    } abkf_cmd_t;

    typedef struct packed {
        logic div_busy;
    } abkf_status_t;

    function automatic logic signed [DataWidth-1:0] sat32(input logic signed [WideWidth-1:0] v);
        logic signed [WideWidth-1:0] hi;
        logic signed [WideWidth-1:0] lo;
        hi = WideWidth'(signed'({1'b0, {(DataWidth-1){1'b1}}}));
        lo = -hi - WideWidth'(1);
        if (v > hi)
            return hi[DataWidth-1:0];
        else if (v < lo)
            return lo[DataWidth-1:0];
        else
            return v[DataWidth-1:0];
    endfunction

    function automatic logic signed [WideWidth-1:0] rescale(input logic signed [WideWidth-1:0] v);
        logic [WideWidth-1:0] m;
        logic [WideWidth-1:0] r;
        m = v[WideWidth-1] ? WideWidth'(-v) : WideWidth'(v);
        r = (m + (WideWidth'(1) << (FracBits - 1))) >> FracBits;
        return v[WideWidth-1] ? -signed'(r) : signed'(r);
    endfunction

endpackage

### hw/rtl/abkf_if.sv
interface abkf_in_if;
    import abkf_pkg::*;
    logic valid;
    logic ready;
    logic signed [DataWidth-1:0] angle_measured;
    logic signed [DataWidth-1:0] rate_measured;
    logic [DtWidth-1:0]          time_step;
    modport source (output valid, angle_measured, rate_measured, time_step, input ready);
    modport sink (input valid, angle_measured, rate_measured, time_step, output ready);
endinterface

interface abkf_out_if;
    import abkf_pkg::*;
    logic valid;
    logic ready;
    logic signed [DataWidth-1:0] angle_estimate;
    modport source (output valid, angle_estimate, input ready);
    modport sink (input valid, angle_estimate, output ready);
endinterface

### hw/rtl/abkf_div.sv
module abkf_div
    import abkf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DivWidth-1:0]  dividend,
    input  logic signed [DivWidth-1:0]  divisor,
    output logic                        busy,
    output logic signed [DivWidth-1:0]  quotient
);

    localparam int CntWidth = $clog2(DivWidth + 1);

    logic [DivWidth-1:0] rem_reg, rem_next;
    logic [DivWidth-1:0] quo_reg, quo_next;
    logic [DivWidth-1:0] den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DivWidth:0]   trial;
    logic [DivWidth-1:0] shifted;

    // restoring divide on magnitudes, one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[DivWidth-2:0], quo_reg[DivWidth-1]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[DivWidth-1] ? DivWidth'(-dividend) : dividend;
            den_next  = divisor[DivWidth-1] ? DivWidth'(-divisor) : divisor;
            neg_next  = dividend[DivWidth-1] ^ divisor[DivWidth-1];
            cnt_next  = CntWidth'(DivWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DivWidth])
            begin
                rem_next = trial[DivWidth-1:0];
                quo_next = {quo_reg[DivWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DivWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntWidth'(1);
            if (cnt_reg == CntWidth'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

### hw/rtl/abkf_datapath.sv
module abkf_datapath
    import abkf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  abkf_cmd_t                   cmd,
    output abkf_status_t                status,
    output logic                        s_zero,
    input  logic signed [DataWidth-1:0] angle_measured,
    input  logic signed [DataWidth-1:0] rate_measured,
    input  logic [DtWidth-1:0]          time_step,
    input  logic                        cfg_we,
    input  logic [CfgIdxWidth-1:0]      cfg_index,
    input  logic [DataWidth-1:0]        cfg_data,
    output logic signed [DataWidth-1:0] angle_estimate
);

    typedef logic signed [WideWidth-1:0] wide_t;

    logic [DataWidth-1:0] qa_reg, qb_reg, r_reg;
    logic signed [DataWidth-1:0] angle_reg, bias_reg;
    logic signed [DataWidth-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DataWidth-1:0] meas_reg, gyro_reg;
    logic [DtWidth-1:0]          dt_reg;
    logic signed [DataWidth-1:0] rate_reg, t_reg, y_reg, k0_reg, k1_reg;
    logic signed [DataWidth+2:0] inner_reg;
    logic signed [DataWidth+1:0] s_reg;
    logic signed [DataWidth-1:0] out_reg;

    // c10 and c11 need the old p00 and p01: c00 and c01 write them first
    logic signed [DataWidth-1:0] p00_keep_reg;
    logic signed [DataWidth-1:0] p01_keep_reg;

    logic signed [DataWidth+2:0] mul_a;
    logic signed [DataWidth+2:0] mul_b;
    wide_t                       prod;
    wide_t                       resc;
    wide_t                       wa;
    logic signed [DivWidth-1:0]  div_dividend;
    logic signed [DivWidth-1:0]  div_q;
    logic                        div_busy;
    wide_t                       qsat;

    abkf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (DivWidth'(s_reg)),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.div_busy = div_busy;
    assign s_zero = (s_reg == '0);
    assign div_dividend = (cmd.op == OP_DIV0) ? (DivWidth'(p00_reg) <<< FracBits)
                                                : (DivWidth'(p10_reg) <<< FracBits);
    assign qsat = WideWidth'(div_q);

    // single shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_ANGLE:
            begin
                mul_a = 35'(rate_reg);
                mul_b = signed'(35'({1'b0, dt_reg}));
            end
            OP_T:
            begin
                mul_a = 35'(p11_reg);
                mul_b = signed'(35'({1'b0, dt_reg}));
            end
            OP_P00:
            begin
                mul_a = inner_reg;
                mul_b = signed'(35'({1'b0, dt_reg}));
            end
            OP_P11:
            begin
                mul_a = signed'(35'({1'b0, qb_reg}));
                mul_b = signed'(35'({1'b0, dt_reg}));
            end
            OP_CA:
            begin
                mul_a = 35'(k0_reg);
                mul_b = 35'(y_reg);
            end
            OP_CB:
            begin
                mul_a = 35'(k1_reg);
                mul_b = 35'(y_reg);
            end
            OP_C00:
            begin
                mul_a = 35'(p00_reg);
                mul_b = 35'(k0_reg);
            end
            OP_C01:
            begin
                mul_a = 35'(p01_reg);
                mul_b = 35'(k0_reg);
            end
            OP_C10:
            begin
                mul_a = 35'(p00_keep_reg);
                mul_b = 35'(k1_reg);
            end
            OP_C11:
            begin
                mul_a = 35'(p01_keep_reg);
                mul_b = 35'(k1_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = WideWidth'(mul_a) * WideWidth'(mul_b);
        resc = rescale(prod);
        wa   = WideWidth'(gyro_reg) - WideWidth'(bias_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg    <= QaReset;
            qb_reg    <= QbReset;
            r_reg     <= RReset;
            angle_reg <= '0;
            bias_reg  <= BiasReset;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CfgQa: qa_reg <= cfg_data;
                    CfgQb: qb_reg <= cfg_data;
                    CfgR:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_ANGLE: angle_reg <= sat32(WideWidth'(angle_reg) + resc);
                OP_P00:   p00_reg   <= sat32(WideWidth'(p00_reg) + resc);
                OP_P11:
                begin
                    p11_reg <= sat32(WideWidth'(p11_reg) + resc);
                    p01_reg <= sat32(WideWidth'(p01_reg) - WideWidth'(t_reg));
                    p10_reg <= sat32(WideWidth'(p10_reg) - WideWidth'(t_reg));
                end
                OP_CA:    angle_reg <= sat32(WideWidth'(angle_reg) + resc);
                OP_CB:    bias_reg  <= sat32(WideWidth'(bias_reg) + resc);
                OP_C00:   p00_reg   <= sat32(WideWidth'(p00_reg) - resc);
                OP_C01:   p01_reg   <= sat32(WideWidth'(p01_reg) - resc);
                OP_C10:   p10_reg   <= sat32(WideWidth'(p10_reg) - resc);
                OP_C11:   p11_reg   <= sat32(WideWidth'(p11_reg) - resc);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= angle_measured;
            gyro_reg <= rate_measured;
            dt_reg   <= time_step;
        end
        unique case (cmd.op)
            OP_RATE:  rate_reg  <= sat32(wa);
            OP_T:     t_reg     <= resc[DataWidth-1:0];
            OP_INNER: inner_reg <= (DataWidth+3)'(WideWidth'(t_reg) - WideWidth'(p01_reg)
                                   - WideWidth'(p10_reg) + WideWidth'({1'b0, qa_reg}));
            OP_S:
            begin
                s_reg <= (DataWidth+2)'(WideWidth'(p00_reg) + WideWidth'({1'b0, r_reg}));
                y_reg <= sat32(WideWidth'(meas_reg) - WideWidth'(angle_reg));
                k0_reg <= '0;
                k1_reg <= '0;
            end
            OP_DIV0:  k0_reg <= sat32(qsat);
            OP_DIV1:  k1_reg <= sat32(qsat);
            OP_CB:
            begin
                p00_keep_reg <= p00_reg;
                p01_keep_reg <= p01_reg;
            end
            default: ;
        endcase
        if (cmd.out_load)
            out_reg <= angle_reg;
    end

    assign angle_estimate = out_reg;

endmodule

### hw/rtl/abkf_ctrl.sv
module abkf_ctrl
    import abkf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  logic         s_zero,
    input  abkf_status_t status,
    output abkf_cmd_t    cmd
);

    abkf_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid && in_ready) state_next = ST_RATE;
            ST_RATE:      state_next = ST_ANGLE;
            ST_ANGLE:     state_next = ST_T;
            ST_T:         state_next = ST_INNER;
            ST_INNER:     state_next = ST_P00;
            ST_P00:       state_next = ST_P11;
            ST_P11:       state_next = ST_S;
            ST_S:         state_next = ST_DIV0;
            ST_DIV0:      state_next = s_zero ? ST_CA : ST_DIV0_WAIT;
            ST_DIV0_WAIT: if (!status.div_busy) state_next = ST_DIV1;
            ST_DIV1:      state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (!status.div_busy) state_next = ST_CA;
            ST_CA:        state_next = ST_CB;
            ST_CB:        state_next = ST_C00;
            ST_C00:       state_next = ST_C01;
            ST_C01:       state_next = ST_C10;
            ST_C10:       state_next = ST_C11;
            ST_C11:       state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '{load: 1'b0, op: OP_NONE, div_start: 1'b0, out_load: 1'b0};
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:      cmd.load = in_valid && in_ready;
            ST_RATE:      cmd.op = OP_RATE;
            ST_ANGLE:     cmd.op = OP_ANGLE;
            ST_T:         cmd.op = OP_T;
            ST_INNER:     cmd.op = OP_INNER;
            ST_P00:       cmd.op = OP_P00;
            ST_P11:       cmd.op = OP_P11;
            ST_S:         cmd.op = OP_S;
            ST_DIV0:
            begin
                // zero divisor keeps both gains at zero
                cmd.op        = s_zero ? OP_NONE : OP_DIV0;
                cmd.div_start = !s_zero;
            end
            ST_DIV0_WAIT: cmd.op = OP_DIV0;
            ST_DIV1:
            begin
                cmd.op        = OP_DIV1;
                cmd.div_start = 1'b1;
            end
            ST_DIV1_WAIT: cmd.op = OP_DIV1;
            ST_CA:        cmd.op = OP_CA;
            ST_CB:        cmd.op = OP_CB;
            ST_C00:       cmd.op = OP_C00;
            ST_C01:       cmd.op = OP_C01;
            ST_C10:       cmd.op = OP_C10;
            ST_C11:       cmd.op = OP_C11;
            ST_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/angle_bias_kalman_filter.sv
// Two-state angle and gyro-bias Kalman filter, Q16.16 angles, Q8.24 covariance.
// Most of the work on a request is two serial 58-step divides for the gains
// behind one shared multiplier; when P00 plus measurement noise is zero the
// divides are skipped. The next request is taken the cycle after the result
// has been delivered. Write noise registers only while idle.
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    abkf_in_if.sink                in_ch,
    abkf_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [DataWidth-1:0]   cfg_data
);

    abkf_cmd_t    cmd;
    abkf_status_t status;
    logic         s_zero;

    abkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .s_zero    (s_zero),
        .status    (status),
        .cmd       (cmd)
    );

    abkf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .s_zero         (s_zero),
        .angle_measured (in_ch.angle_measured),
        .rate_measured  (in_ch.rate_measured),
        .time_step      (in_ch.time_step),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .angle_estimate (out_ch.angle_estimate)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import abkf_pkg::*;

    localparam logic [CfgIdxWidth-1:0] CfgSpare = 2'd3;
    localparam int SettleCycles = 200;

    class kalman_scoreboard;
        longint noise_angle;
        longint noise_bias;
        longint noise_meas;
        longint angle_est;
        longint bias_est;
        longint cov[4];
        logic signed [DataWidth-1:0] angle_fifo[$];
        int mismatches;
        int matched;
        int requests;

        function new();
            noise_angle = QaReset;
            noise_bias  = QbReset;
            noise_meas  = RReset;
            angle_est   = 0;
            bias_est    = BiasReset;
            foreach (cov[i]) cov[i] = 0;
            mismatches  = 0;
            matched     = 0;
            requests    = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // drop 24 fraction bits, round half away from zero
        function longint round_q24(longint v);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (64'sd1 <<< 23)) >>> 24;
            return (v < 0) ? -m : m;
        endfunction

        function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [DataWidth-1:0] val);
            if (idx == CfgQa) noise_angle = longint'(val);
            else if (idx == CfgQb) noise_bias = longint'(val);
            else if (idx == CfgR) noise_meas = longint'(val);
        endfunction

        function void note_request(logic signed [DataWidth-1:0] meas_in,
                                   logic signed [DataWidth-1:0] rate_in,
                                   logic [DtWidth-1:0] dt_in);
            longint meas, gyro, dt, p00, p01, p10, p11;
            longint rate, t, inner, innov, s, k0, k1;
            meas = longint'(meas_in);
            gyro = longint'(rate_in);
            dt   = longint'({40'd0, dt_in});
            p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
            k0 = 0; k1 = 0;
            rate = clamp32(gyro - bias_est);
            angle_est = clamp32(angle_est + round_q24(rate * dt));
            t = round_q24(p11 * dt);
            inner = t - p01 - p10 + noise_angle;
            p00 = clamp32(p00 + round_q24(inner * dt));
            p01 = clamp32(p01 - t);
            p10 = clamp32(p10 - t);
            p11 = clamp32(p11 + round_q24(noise_bias * dt));
            innov = clamp32(meas - angle_est);
            s = p00 + noise_meas;
            if (s != 0)
            begin
                k0 = clamp32((p00 * (64'sd1 <<< 24)) / s);
                k1 = clamp32((p10 * (64'sd1 <<< 24)) / s);
            end
            angle_est = clamp32(angle_est + round_q24(k0 * innov));
            bias_est  = clamp32(bias_est + round_q24(k1 * innov));
            cov[0] = clamp32(p00 - round_q24(p00 * k0));
            cov[1] = clamp32(p01 - round_q24(p01 * k0));
            cov[2] = clamp32(p10 - round_q24(p00 * k1));
            cov[3] = clamp32(p11 - round_q24(p01 * k1));
            angle_fifo.push_back(angle_est[DataWidth-1:0]);
            requests++;
        endfunction

        function void check_result(logic signed [DataWidth-1:0] got);
            logic signed [DataWidth-1:0] want;
            if (angle_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected angle_estimate %0d", got);
                return;
            end
            want = angle_fifo.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("angle_estimate mismatch: expected %0d got %0d", want, got);
            end
            else
                matched++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [DataWidth-1:0] cfg_data = '0;

    abkf_in_if in_ch();
    abkf_out_if out_ch();

    angle_bias_kalman_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kalman_scoreboard sb = new();
    int burst_left = 0;
    logic [15:0] stall_word = 16'hffff;
    int stall_pos = 0;
    int cfg_writes = 0;

    always #4 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.angle_measured = '0;
        in_ch.rate_measured = '0;
        in_ch.time_step = '0;
        out_ch.ready = 1'b0;
    end

    // result side: ready follows a 16-bit stall word, reloaded after its last bit
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.angle_estimate);
        if (stall_pos == 15)
        begin
            stall_pos <= 0;
            case ($urandom_range(0, 3))
                0: stall_word <= 16'hffff;
                1: stall_word <= 16'h0001;
                default: stall_word <= 16'($urandom);
            endcase
        end
        else
            stall_pos <= stall_pos + 1;
        out_ch.ready <= rst_n && stall_word[stall_pos];
    end

    task automatic send_request(logic signed [DataWidth-1:0] a,
                                logic signed [DataWidth-1:0] r,
                                logic [DtWidth-1:0] dt);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
        end
        in_ch.valid <= 1'b1;
        in_ch.angle_measured <= a;
        in_ch.rate_measured <= r;
        in_ch.time_step <= dt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(a, r, dt);
        burst_left--;
    endtask

    // write enable stays high; the caller drops it after the last write
    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [DataWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.angle_fifo.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic random_requests(int n);
        logic signed [DataWidth-1:0] a, r;
        logic [DtWidth-1:0] dt;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                a = $urandom;
                r = $urandom;
                dt = DtWidth'($urandom);
            end
            else
            begin
                a = $signed($urandom_range(0, 2 * 11796480)) - 11796480;
                r = $signed($urandom_range(0, 2 * 32768000)) - 32768000;
                dt = DtWidth'($urandom_range(8389, 335544));
            end
            send_request(a, r, dt);
        end
    endtask

    initial
    begin
        logic [DataWidth-1:0] qa_set[5];
        logic [DataWidth-1:0] qb_set[5];
        logic [DataWidth-1:0] r_set[5];
        qa_set = '{32'd0, 32'hffffffff, 32'd16777, $urandom, 32'd1677721};
        qb_set = '{32'd0, 32'hffffffff, 32'd50332, $urandom, 32'd0};
        r_set  = '{32'd1, 32'hffffffff, 32'd503316, $urandom | 32'd1, 32'd1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes at reset settings
        send_request(32'sh7fffffff, 32'sh0, 24'd16777);
        send_request(32'sh80000000, 32'sh0, 24'd16777);
        send_request(32'sh0, 32'sh7fffffff, 24'hffffff);
        send_request(32'sh0, 32'sh80000000, 24'hffffff);
        send_request(32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
        send_request(32'sh80000000, 32'sh80000000, 24'hffffff);
        send_request(32'sh0, 32'sh0, 24'd0);
        send_request(32'sh00010000, 32'sh00030000, 24'd0);
        send_request(32'shffffffff, 32'sh00000001, 24'd1);
        send_request(32'sh005a0000, 32'sh00030000, 24'd167772);
        send_request(32'sh005a0000, 32'sh00030000, 24'd167772);
        random_requests(120);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            write_reg(CfgQa, qa_set[ph]);
            write_reg(CfgQb, qb_set[ph]);
            write_reg(CfgR, r_set[ph]);
            if (ph == 2)
                write_reg(CfgSpare, $urandom);
            cfg_we <= 1'b0;
            send_request(32'sh7fffffff, 32'sh80000000, 24'hffffff);
            send_request(32'sh80000000, 32'sh7fffffff, 24'hffffff);
            random_requests(140);
        end

        wait_idle();
        $display("%0d requests over 6 noise settings, %0d register writes, %0d results matched",
                 sb.requests, cfg_writes, sb.matched);
        if (sb.mismatches == 0 && sb.angle_fifo.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d results outstanding", sb.angle_fifo.size());
        $display("simulation failed");
        $finish;
    end

endmodule
